### rtl/ipc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the irrigation pump controller.
// No dependencies; every other file imports this package.
package ipc_pkg;

	localparam int FUNC_W   = 4;
	localparam int VALUE_W  = 14;
	localparam int LEVEL_W  = 12;
	localparam int CFG_IDX_W = 4;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 12'd4095;
	localparam logic [LEVEL_W-1:0] WATER_MIN_RESET = 12'd200;
	localparam logic [LEVEL_W-1:0] GAP_RESET       = 12'd300;
	localparam logic [LEVEL_W-1:0] DRY_RESET       = 12'd1500;
	localparam logic [LEVEL_W-1:0] WET_RESET       = 12'd1800;

	localparam logic [VALUE_W-1:0] SRC_BUTTON = 14'd1;
	localparam logic [VALUE_W-1:0] SRC_REMOTE = 14'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WATER_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST_GAP  = 4'd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_VIEW     = 4'd0,
		FN_MODE     = 4'd1,
		FN_SET_MODE = 4'd2,
		FN_SET_DRY  = 4'd3,
		FN_PUMP_ON  = 4'd4,
		FN_PUMP_OFF = 4'd5,
		FN_SOIL     = 4'd6,
		FN_LIGHT    = 4'd7,
		FN_WATER    = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		CTRL_MANUAL = 2'd0,
		CTRL_AUTO   = 2'd1,
		CTRL_REMOTE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SHOW_ALL   = 2'd0,
		SHOW_SOIL  = 2'd1,
		SHOW_WATER = 2'd2,
		SHOW_LIGHT = 2'd3
	} view_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] water_min;
		logic [LEVEL_W-1:0] hyst_gap;
	} ipc_cfg_t;

	typedef struct packed {
		logic               pump_on;
		logic [1:0]         mode_now;
		logic [1:0]         view_now;
		logic [LEVEL_W-1:0] dry_level;
		logic [LEVEL_W-1:0] wet_level;
		logic [LEVEL_W-1:0] soil_level;
		logic [LEVEL_W-1:0] light_level;
		logic [LEVEL_W-1:0] water_level;
	} ipc_result_t;

endpackage

### rtl/ipc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: message input, result output, config write.
// Depends on ipc_pkg for field widths.
interface ipc_in_if import ipc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface ipc_out_if import ipc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               pump_on;
	logic [1:0]         mode_now;
	logic [1:0]         view_now;
	logic [LEVEL_W-1:0] dry_level;
	logic [LEVEL_W-1:0] wet_level;
	logic [LEVEL_W-1:0] soil_level;
	logic [LEVEL_W-1:0] light_level;
	logic [LEVEL_W-1:0] water_level;

	modport source (output valid, output pump_on, output mode_now, output view_now,
		output dry_level, output wet_level, output soil_level, output light_level,
		output water_level, input ready);
	modport sink (input valid, input pump_on, input mode_now, input view_now,
		input dry_level, input wet_level, input soil_level, input light_level,
		input water_level, output ready);
endinterface

interface ipc_cfg_if import ipc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEVEL_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/irrigation_pump_controller.sv
`timescale 1ns / 1ps
// Irrigation pump controller top level: config registers, control core, result buffer.
// Depends on ipc_pkg, ipc_if, ipc_cfg_regs, ipc_ctrl_core and ipc_out_buf.

// One message (command or sensor sample) is taken per cycle while in_ch is ready and
// produces exactly one result, the full controller state after that message, on out_ch.
// The state registers update as the message is accepted, so the next message in the
// following cycle already sees it. Results go through a two-entry buffer; in_ch
// stalls only while both entries are full. Configuration writes are always ready,
// take effect on the next message, and must be issued while no request is in flight.
module irrigation_pump_controller import ipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ipc_in_if.sink    in_ch,
	ipc_out_if.source out_ch,
	ipc_cfg_if.sink   cfg_ch
);

	ipc_cfg_t    cfg;
	ipc_result_t result;
	logic        can_push;
	logic        msg_en;

	assign in_ch.ready = can_push;
	assign msg_en      = in_ch.valid & can_push;

	ipc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	ipc_ctrl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.msg_en (msg_en),
		.func   (in_ch.func),
		.value  (in_ch.value),
		.cfg    (cfg),
		.result (result)
	);

	ipc_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (msg_en),
		.push_data (result),
		.can_push  (can_push),
		.out_ch    (out_ch)
	);

endmodule

### rtl/ipc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers: reservoir minimum level and hysteresis gap.
// Depends on ipc_pkg and ipc_cfg_if.
module ipc_cfg_regs import ipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ipc_cfg_if.sink   cfg_ch,
	output ipc_cfg_t  cfg
);

	logic [LEVEL_W-1:0] water_min_q;
	logic [LEVEL_W-1:0] hyst_gap_q;
	logic               wr_en;

	// writes never stall
	assign cfg_ch.ready = 1'b1;
	assign wr_en        = cfg_ch.valid & cfg_ch.ready;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_min_q <= WATER_MIN_RESET;
			hyst_gap_q  <= GAP_RESET;
		end else if (wr_en) begin
			if (cfg_ch.index == CFG_WATER_MIN) begin
				water_min_q <= cfg_ch.data;
			end
			if (cfg_ch.index == CFG_HYST_GAP) begin
				hyst_gap_q <= cfg_ch.data;
			end
		end
	end

	assign cfg.water_min = water_min_q;
	assign cfg.hyst_gap  = hyst_gap_q;

endmodule

### rtl/ipc_ctrl_core.sv
`timescale 1ns / 1ps
// Controller state and per-message update: commands, samples and auto rule.
// Depends on ipc_pkg.
module ipc_ctrl_core import ipc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               msg_en,
	input  logic [FUNC_W-1:0]  func,
	input  logic [VALUE_W-1:0] value,
	input  ipc_cfg_t           cfg,
	output ipc_result_t        result
);

	mode_t              mode_q, mode_d;
	view_t              view_q, view_d;
	logic               pump_q, pump_d;
	logic [LEVEL_W-1:0] soil_q, soil_d;
	logic [LEVEL_W-1:0] light_q, light_d;
	logic [LEVEL_W-1:0] water_q, water_d;
	logic [LEVEL_W-1:0] dry_q, dry_d;
	logic [LEVEL_W-1:0] wet_q, wet_d;
	logic [LEVEL_W-1:0] sample_sat;
	logic [LEVEL_W-1:0] value_lvl;
	logic               value_in_range;
	logic               req_ok;

	assign value_lvl      = value[LEVEL_W-1:0];
	assign value_in_range = (value[VALUE_W-1:LEVEL_W] == '0);
	assign sample_sat     = value_in_range ? value_lvl : LEVEL_MAX;
	assign req_ok = ((mode_q == CTRL_MANUAL) && (value == SRC_BUTTON)) ||
		((mode_q == CTRL_REMOTE) && (value == SRC_REMOTE));

	// next state for one message, then the auto hysteresis rule
	always_comb begin
		mode_d  = mode_q;
		view_d  = view_q;
		pump_d  = pump_q;
		soil_d  = soil_q;
		light_d = light_q;
		water_d = water_q;
		dry_d   = dry_q;
		wet_d   = wet_q;
		case (func_t'(func))
			FN_VIEW: begin
				view_d = view_t'(view_q + 2'd1);
			end
			FN_MODE: begin
				case (mode_q)
					CTRL_MANUAL: mode_d = CTRL_AUTO;
					CTRL_AUTO:   mode_d = CTRL_REMOTE;
					default:     mode_d = CTRL_MANUAL;
				endcase
				pump_d = 1'b0;
			end
			FN_SET_MODE: begin
				if (value <= VALUE_W'(CTRL_REMOTE)) begin
					mode_d = mode_t'(value[1:0]);
					pump_d = 1'b0;
				end
			end
			FN_SET_DRY: begin
				if (value_in_range) begin
					dry_d = value_lvl;
					wet_d = (value_lvl > cfg.hyst_gap) ? (value_lvl - cfg.hyst_gap) : '0;
				end
			end
			FN_PUMP_ON: begin
				if (req_ok) pump_d = 1'b1;
			end
			FN_PUMP_OFF: begin
				if (req_ok) pump_d = 1'b0;
			end
			FN_SOIL:  soil_d  = sample_sat;
			FN_LIGHT: light_d = sample_sat;
			FN_WATER: water_d = sample_sat;
			default: ;
		endcase
		if (mode_d == CTRL_AUTO) begin
			if ((soil_d > dry_d) && (water_d > cfg.water_min)) begin
				pump_d = 1'b1;
			end else if ((soil_d < wet_d) || (water_d < cfg.water_min)) begin
				pump_d = 1'b0;
			end
		end
	end

	// state registers, updated once per accepted message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= CTRL_MANUAL;
			view_q  <= SHOW_ALL;
			pump_q  <= 1'b0;
			soil_q  <= '0;
			light_q <= '0;
			water_q <= '0;
			dry_q   <= DRY_RESET;
			wet_q   <= WET_RESET;
		end else if (msg_en) begin
			mode_q  <= mode_d;
			view_q  <= view_d;
			pump_q  <= pump_d;
			soil_q  <= soil_d;
			light_q <= light_d;
			water_q <= water_d;
			dry_q   <= dry_d;
			wet_q   <= wet_d;
		end
	end

	// result shows the state after this message
	assign result.pump_on     = pump_d;
	assign result.mode_now    = mode_d;
	assign result.view_now    = view_d;
	assign result.dry_level   = dry_d;
	assign result.wet_level   = wet_d;
	assign result.soil_level  = soil_d;
	assign result.light_level = light_d;
	assign result.water_level = water_d;

endmodule

### rtl/ipc_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer (output register plus skid register).
// Depends on ipc_pkg and ipc_out_if.
module ipc_out_buf import ipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ipc_result_t push_data,
	output logic        can_push,
	ipc_out_if.source   out_ch
);

	logic        main_valid_q;
	logic        skid_valid_q;
	ipc_result_t main_q;
	ipc_result_t skid_q;
	logic        pop;

	assign can_push = !skid_valid_q;
	assign pop      = main_valid_q & out_ch.ready;

	// occupancy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign out_ch.valid       = main_valid_q;
	assign out_ch.pump_on     = main_q.pump_on;
	assign out_ch.mode_now    = main_q.mode_now;
	assign out_ch.view_now    = main_q.view_now;
	assign out_ch.dry_level   = main_q.dry_level;
	assign out_ch.wet_level   = main_q.wet_level;
	assign out_ch.soil_level  = main_q.soil_level;
	assign out_ch.light_level = main_q.light_level;
	assign out_ch.water_level = main_q.water_level;

endmodule

### rtl/ipc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the irrigation pump controller, bound to the top level.
// Depends on ipc_pkg and irrigation_pump_controller.
module ipc_checker import ipc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       pump_on,
	input logic [1:0] mode_now,
	input logic [1:0] view_now
);

	logic       seen_q;
	logic [1:0] last_mode_q;
	logic [1:0] last_view_q;
	logic       out_take;

	assign out_take = out_valid & out_ready;

	// remember the previous delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_mode_q <= CTRL_MANUAL;
			last_view_q <= SHOW_ALL;
		end else if (out_take) begin
			seen_q      <= 1'b1;
			last_mode_q <= mode_now;
			last_view_q <= view_now;
		end
	end

	// a result waiting downstream stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// after every accepted request, out_valid is high in the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted request");

	// a mode change into a non-auto mode leaves the pump off
	a_mode_pump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q && (mode_now != last_mode_q) && (mode_now != CTRL_AUTO)
		|-> !pump_on)
		else $error("pump running after mode change");

	// view advances by at most one step per result
	a_view_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |->
		(view_now == last_view_q) || (view_now == 2'(last_view_q + 2'd1)))
		else $error("view jumped");

	// only the three defined modes are ever shown
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode_now <= CTRL_REMOTE))
		else $error("illegal mode code");

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pump_on   (out_ch.pump_on),
	.mode_now  (out_ch.mode_now),
	.view_now  (out_ch.view_now)
);

### bench/irrigation_pump_controller_test.sv
`timescale 1ns / 1ps
// Self-checking bench for irrigation_pump_controller: a directed table, then random phases.
// Depends on ipc_pkg, the ipc_in_if/ipc_out_if/ipc_cfg_if interfaces and the controller RTL.
module irrigation_pump_controller_test;
	import ipc_pkg::*;

	localparam int N_DIRECTED   = 26;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 100;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RESET_CYCLES = 7;

	// func codes the block decodes to no command
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd9;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;
	localparam logic [VALUE_W-1:0] VALUE_TOP = 14'h3FFF;

	typedef struct packed {
		logic [FUNC_W-1:0]  fn;
		logic [VALUE_W-1:0] val;
		logic               fixed;
		ipc_result_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ipc_in_if  in_ch();
	ipc_out_if out_ch();
	ipc_cfg_if cfg_ch();

	irrigation_pump_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Controller copy kept by the bench
	mode_t              ctl_mode;
	view_t              ctl_view;
	logic               ctl_pump;
	logic [LEVEL_W-1:0] ctl_soil, ctl_light, ctl_water, ctl_dry, ctl_wet;
	logic [LEVEL_W-1:0] cfg_water_min, cfg_gap;

	ipc_result_t awaited_states[$];

	int in_idle_pct;
	int out_idle_pct;
	int stall_left = 0;
	int idle_cycles = 0;
	int mismatch_count = 0;
	int results_seen = 0;
	bit fixed_now = 1'b0;
	ipc_result_t fixed_want;

	int in_idle_by_phase  [N_PHASES] = '{20, 0, 40, 0, 30, 0};
	int out_idle_by_phase [N_PHASES] = '{20, 40, 0, 0, 30, 0};

	// Directed table; rows with fixed set carry the state typed in by hand
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{FN_VIEW, 14'd0, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_SOIL, 12'd1500, 12'd1800, 12'd0, 12'd0, 12'd0}},
		'{FN_VIEW, 14'd0, 1'b0, '0},
		'{FN_VIEW, 14'd0, 1'b0, '0},
		'{FN_VIEW, VALUE_TOP, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd1500, 12'd1800, 12'd0, 12'd0, 12'd0}},
		'{FN_SOIL, VALUE_TOP, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd1500, 12'd1800, 12'd4095, 12'd0, 12'd0}},
		'{FN_LIGHT, 14'd4095, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd1500, 12'd1800, 12'd4095, 12'd4095, 12'd0}},
		'{FN_WATER, 14'd4096, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd1500, 12'd1800, 12'd4095, 12'd4095, 12'd4095}},
		'{FN_PUMP_ON, SRC_BUTTON, 1'b0, '0},
		'{FN_PUMP_ON, SRC_REMOTE, 1'b0, '0},
		'{FN_PUMP_OFF, SRC_REMOTE, 1'b0, '0},
		'{FN_PUMP_OFF, SRC_BUTTON, 1'b0, '0},
		'{FN_SET_MODE, 14'd3, 1'b0, '0},
		'{FN_SET_MODE, VALUE_TOP, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd1500, 12'd1800, 12'd4095, 12'd4095, 12'd4095}},
		'{FN_SET_DRY, 14'd4096, 1'b0, '0},
		'{FN_SET_DRY, 14'd4095, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd4095, 12'd3795, 12'd4095, 12'd4095, 12'd4095}},
		'{FN_SET_DRY, 14'd300, 1'b0, '0},
		'{FN_SET_DRY, 14'd0, 1'b1,
			'{1'b0, CTRL_MANUAL, SHOW_ALL, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095}},
		'{FN_SET_MODE, 14'd2, 1'b0, '0},
		'{FN_PUMP_ON, SRC_REMOTE, 1'b0, '0},
		'{FN_PUMP_ON, SRC_BUTTON, 1'b0, '0},
		'{FN_SPARE_HI, VALUE_TOP, 1'b0, '0},
		'{FN_MODE, 14'd0, 1'b0, '0},
		'{FN_MODE, 14'd0, 1'b0, '0},
		'{FN_SET_DRY, 14'd2000, 1'b0, '0},
		'{FN_SOIL, 14'd1800, 1'b0, '0},
		'{FN_SOIL, 14'd1000, 1'b0, '0}
	};

	function automatic logic [LEVEL_W-1:0] clamp_level(logic [VALUE_W-1:0] v);
		return (v > VALUE_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
	endfunction

	// a level a few counts either side of a threshold
	function automatic logic [VALUE_W-1:0] jitter_level(logic [LEVEL_W-1:0] center);
		int v;
		v = int'(center) + int'($urandom_range(6)) - 3;
		return (v < 0) ? '0 : VALUE_W'(v);
	endfunction

	// Apply one message to the bench copy and return the state it leaves
	function automatic ipc_result_t advance_controller(logic [FUNC_W-1:0] fn,
			logic [VALUE_W-1:0] val);
		ipc_result_t r;
		bit honored;
		honored = (ctl_mode == CTRL_MANUAL && val == SRC_BUTTON) ||
			(ctl_mode == CTRL_REMOTE && val == SRC_REMOTE);
		case (fn)
			FN_VIEW: ctl_view = view_t'(ctl_view + 2'd1);
			FN_MODE: begin
				ctl_mode = (ctl_mode == CTRL_REMOTE) ? CTRL_MANUAL : mode_t'(ctl_mode + 2'd1);
				ctl_pump = 1'b0;
			end
			FN_SET_MODE: begin
				if (val <= VALUE_W'(CTRL_REMOTE)) begin
					ctl_mode = mode_t'(val[1:0]);
					ctl_pump = 1'b0;
				end
			end
			FN_SET_DRY: begin
				if (val <= VALUE_W'(LEVEL_MAX)) begin
					ctl_dry = val[LEVEL_W-1:0];
					ctl_wet = (ctl_dry > cfg_gap) ? ctl_dry - cfg_gap : '0;
				end
			end
			FN_PUMP_ON: if (honored) ctl_pump = 1'b1;
			FN_PUMP_OFF: if (honored) ctl_pump = 1'b0;
			FN_SOIL: ctl_soil = clamp_level(val);
			FN_LIGHT: ctl_light = clamp_level(val);
			FN_WATER: ctl_water = clamp_level(val);
			default: ;
		endcase
		// hysteresis on soil and reservoir, auto mode only
		if (ctl_mode == CTRL_AUTO) begin
			if (ctl_soil > ctl_dry && ctl_water > cfg_water_min)
				ctl_pump = 1'b1;
			else if (ctl_soil < ctl_wet || ctl_water < cfg_water_min)
				ctl_pump = 1'b0;
		end
		r = '{ctl_pump, ctl_mode, ctl_view, ctl_dry, ctl_wet, ctl_soil, ctl_light, ctl_water};
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR %0t ns, result %0d: %s", $time, results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// One request on the message channel, with an optional gap ahead of it
	task automatic send_message(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] val,
			bit fixed, ipc_result_t want);
		if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat ($urandom_range(13, 1) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.func  <= fn;
		in_ch.value <= val;
		fixed_now = fixed;
		fixed_want = want;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] wdata);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= wdata;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	// Result side backpressure: random bursts with ready held low
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
			out_ch.ready <= 1'b0;
			stall_left <= $urandom_range(12, 0);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Handshake tracking, prediction, result check and watchdog
	always @(posedge clk) begin : handshakes
		ipc_result_t predicted;
		ipc_result_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved = 1'b1;
				if (cfg_ch.index == CFG_WATER_MIN)
					cfg_water_min = cfg_ch.data;
				else if (cfg_ch.index == CFG_HYST_GAP)
					cfg_gap = cfg_ch.data;
			end
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				predicted = advance_controller(in_ch.func, in_ch.value);
				awaited_states.push_back(fixed_now ? fixed_want : predicted);
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				results_seen++;
				if (awaited_states.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = awaited_states.pop_front();
					check_field("pump_on", LEVEL_W'(out_ch.pump_on), LEVEL_W'(want.pump_on));
					check_field("mode_now", LEVEL_W'(out_ch.mode_now), LEVEL_W'(want.mode_now));
					check_field("view_now", LEVEL_W'(out_ch.view_now), LEVEL_W'(want.view_now));
					check_field("dry_level", out_ch.dry_level, want.dry_level);
					check_field("wet_level", out_ch.wet_level, want.wet_level);
					check_field("soil_level", out_ch.soil_level, want.soil_level);
					check_field("light_level", out_ch.light_level, want.light_level);
					check_field("water_level", out_ch.water_level, want.water_level);
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [FUNC_W-1:0]  fn;
		logic [VALUE_W-1:0] val;
		logic [LEVEL_W-1:0] wmin, gap;
		int pick;
		// every input known from time zero
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = FN_VIEW;
		in_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_WATER_MIN;
		cfg_ch.data = '0;
		// power-on state of the controller copy
		ctl_mode = CTRL_MANUAL;
		ctl_view = SHOW_ALL;
		ctl_pump = 1'b0;
		ctl_soil = '0;
		ctl_light = '0;
		ctl_water = '0;
		ctl_dry = DRY_RESET;
		ctl_wet = WET_RESET;
		cfg_water_min = WATER_MIN_RESET;
		cfg_gap = GAP_RESET;
		in_idle_pct = 15;
		out_idle_pct = 15;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed part, reset configuration
		foreach (directed_rows[i])
			send_message(directed_rows[i].fn, directed_rows[i].val,
				directed_rows[i].fixed, directed_rows[i].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// drain before the registers change
			@(negedge clk) in_ch.valid <= 1'b0;
			while (awaited_states.size() != 0) @(posedge clk);
			case (ph)
				0: begin wmin = '0; gap = '0; end
				1: begin wmin = LEVEL_MAX; gap = LEVEL_MAX; end
				2: begin wmin = '0; gap = LEVEL_MAX; end
				3: begin wmin = LEVEL_MAX; gap = '0; end
				4: begin
					wmin = LEVEL_W'($urandom_range(4095));
					gap = LEVEL_W'($urandom_range(4095));
				end
				default: begin
					wmin = LEVEL_W'($urandom_range(600));
					gap = LEVEL_W'($urandom_range(800));
				end
			endcase
			write_config(CFG_WATER_MIN, wmin);
			write_config(CFG_HYST_GAP, gap);
			in_idle_pct = in_idle_by_phase[ph];
			out_idle_pct = out_idle_by_phase[ph];

			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					// soil samples mostly around the two thresholds
					fn = FN_SOIL;
					case ($urandom_range(4))
						0, 1: val = jitter_level(ctl_dry);
						2, 3: val = jitter_level(ctl_wet);
						default: val = VALUE_W'($urandom);
					endcase
				end else if (pick < 45) begin
					fn = FN_WATER;
					val = ($urandom_range(4) < 3) ? jitter_level(cfg_water_min) : VALUE_W'($urandom);
				end else if (pick < 50) begin
					fn = FN_LIGHT;
					val = VALUE_W'($urandom);
				end else if (pick < 58) begin
					fn = FN_VIEW;
					val = VALUE_W'($urandom);
				end else if (pick < 63) begin
					fn = FN_MODE;
					val = VALUE_W'($urandom);
				end else if (pick < 73) begin
					// lean toward auto so the hysteresis gets exercised
					fn = FN_SET_MODE;
					case ($urandom_range(9))
						0, 1, 2, 3, 4: val = VALUE_W'(CTRL_AUTO);
						5, 6: val = VALUE_W'(CTRL_MANUAL);
						7: val = VALUE_W'(CTRL_REMOTE);
						default: val = VALUE_W'($urandom);
					endcase
				end else if (pick < 81) begin
					fn = FN_SET_DRY;
					case ($urandom_range(9))
						7, 8: val = jitter_level(cfg_gap);
						9: val = VALUE_W'($urandom);
						default: val = VALUE_W'($urandom_range(4095));
					endcase
				end else if (pick < 96) begin
					fn = (pick < 89) ? FN_PUMP_ON : FN_PUMP_OFF;
					val = ($urandom_range(99) < 85) ? VALUE_W'($urandom_range(3)) :
						VALUE_W'($urandom);
				end else begin
					fn = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
					val = VALUE_W'($urandom);
				end
				send_message(fn, val, 1'b0, '0);
			end
		end

		@(negedge clk) in_ch.valid <= 1'b0;
		while (awaited_states.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
